[sv/segment_lcd_frame_formatter_defines.svh]
// Assertion macros for the segment LCD frame formatter.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef SEGMENT_LCD_FRAME_FORMATTER_DEFINES_SVH
`define SEGMENT_LCD_FRAME_FORMATTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SLCD_ASSERT(lbl, prop, msg)
`define SLCD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[sv/slcd_pkg.sv]
// Shared types and constants for the segment LCD frame formatter.
// No dependencies.
package slcd_pkg;

  localparam int unsigned BYTE_COUNT = 11;
  localparam int unsigned POS_W      = 4;
  localparam logic [8:0]  WRITE_CMD  = 9'b101000000;

  typedef logic [BYTE_COUNT-1:0][7:0] frame_bytes_t;

  typedef struct packed {
    logic signed [10:0] big_value;
    logic signed [7:0]  hour_left;
    logic signed [7:0]  hour_right;
    logic [6:0]         day_mask;
    logic [3:0]         home_mask;
    logic [24:0]        icon_flags;
  } frame_t;

endpackage

[sv/slcd_format.sv]
// Combinational formatter: one display frame to the eleven segment bytes.
// Depends on slcd_pkg.
module slcd_format (
  input  slcd_pkg::frame_t       frame,
  output slcd_pkg::frame_bytes_t bytes
);

  localparam logic [7:0] MINUS_BIG  = 8'h20;
  localparam logic [7:0] MINUS_HOUR = 8'h02;

  function automatic logic [7:0] seg_big(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'h5F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h6B;
      4'd3: s = 8'h2F;
      4'd4: s = 8'h36;
      4'd5: s = 8'h3D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h3F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] seg_hour(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'hF5;
      4'd1: s = 8'h60;
      4'd2: s = 8'hB6;
      4'd3: s = 8'hF2;
      4'd4: s = 8'h63;
      4'd5: s = 8'hD3;
      4'd6: s = 8'hD7;
      4'd7: s = 8'h70;
      4'd8: s = 8'hF7;
      4'd9: s = 8'hF3;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Exact for 0..99 by reciprocal multiply.
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = {8'b0, x} * 15'd205;
    return p[14:11];
  endfunction

  // Exact for 0..999 by reciprocal multiply.
  function automatic logic [3:0] div100(input logic [9:0] x);
    logic [15:0] p;
    p = {6'b0, x} * 16'd41;
    return p[15:12];
  endfunction

  // Returns {tens, ones} segment bits for one hour value.
  function automatic logic [15:0] hour_segs(input logic signed [7:0] v);
    logic [7:0] ones;
    logic [7:0] tens;
    logic [7:0] mag;
    logic [3:0] t;
    logic [6:0] o;
    ones = 8'h00;
    tens = 8'h00;
    mag  = -v;
    t    = div10(v[6:0]);
    o    = v[6:0] - 7'(t) * 7'd10;
    priority if (v > 8'sd99) begin
    end else if (v < -8'sd9) begin
      ones = MINUS_HOUR;
    end else if (v[7]) begin
      tens = MINUS_HOUR;
      ones = seg_hour(mag[3:0]);
    end else begin
      ones = seg_hour(o[3:0]);
      tens = seg_hour(t);
    end
    return {tens, ones};
  endfunction

  logic [6:0]  neg_mag;
  logic [3:0]  neg_tens;
  logic [6:0]  neg_ones;
  logic [3:0]  hund;
  logic [9:0]  pos_rem;
  logic [3:0]  pos_tens;
  logic [6:0]  pos_ones;
  logic [10:0] big_neg;
  logic [15:0] hl_segs;
  logic [15:0] hr_segs;
  logic [24:0] f;

  assign f = frame.icon_flags;

  always_comb begin
    big_neg  = -frame.big_value;
    neg_mag  = (frame.big_value < -11'sd99) ? 7'd99 : big_neg[6:0];
    neg_tens = div10(neg_mag);
    neg_ones = neg_mag - 7'(neg_tens) * 7'd10;
    hund     = div100(frame.big_value[9:0]);
    pos_rem  = frame.big_value[9:0] - 10'(hund) * 10'd100;
    pos_tens = div10(pos_rem[6:0]);
    pos_ones = pos_rem[6:0] - 7'(pos_tens) * 7'd10;
    hl_segs  = hour_segs(frame.hour_left);
    hr_segs  = hour_segs(frame.hour_right);

    bytes[0] = {f[0], frame.day_mask};
    bytes[1] = {f[1], 7'b0};
    bytes[2] = {f[2], 7'b0};
    bytes[3] = 8'h00;
    if (frame.big_value <= 11'sd999) begin
      if (frame.big_value[10]) begin
        // The minus overwrites the thermometer icon and the hundreds digit.
        bytes[1] = MINUS_BIG;
        bytes[2] = bytes[2] | seg_big(neg_tens);
        bytes[3] = seg_big(neg_ones[3:0]);
      end else begin
        if (hund != 4'd0) begin
          bytes[1] = bytes[1] | seg_big(hund);
        end
        bytes[2] = bytes[2] | seg_big(pos_tens);
        bytes[3] = seg_big(pos_ones[3:0]);
      end
    end
    bytes[4]  = {frame.home_mask, f[3], f[4], f[5], f[6]};
    bytes[5]  = {4'b0, f[7], 3'b0} | hl_segs[7:0];
    bytes[6]  = {4'b0, f[8], 3'b0} | hl_segs[15:8];
    bytes[7]  = {4'b0, f[9], 3'b0} | hr_segs[7:0];
    bytes[8]  = {4'b0, f[10], 3'b0} | hr_segs[15:8];
    bytes[9]  = {2'b0, f[11], f[12], f[13], f[14], f[15], f[16]};
    bytes[10] = {f[17], f[18], f[19], f[20], f[21], f[22], f[23], f[24]};
  end

endmodule

[sv/segment_lcd_frame_formatter.sv]
// Top level of the segment LCD frame formatter: input register, formatter, burst shifter.
// Depends on slcd_pkg, slcd_format and segment_lcd_frame_formatter_defines.svh.
//
//   channel | direction | beat
//   in_     | input     | one display frame
//   out_    | output    | one command word or one segment byte
//
// Each frame gives twelve output beats, one per cycle while out_ready stays high;
// the burst shifter sends one word a cycle unless the output stalls.
// A frame waits in the input register while the previous burst is sent and is
// formatted into the burst buffer on the cycle the last byte leaves.
// Reset clears the valid and position state only. An output stall holds the
// current word and, once the input register is full, the input channel.
`include "segment_lcd_frame_formatter_defines.svh"
module segment_lcd_frame_formatter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [10:0] in_big_value,
  input  logic signed [7:0]  in_hour_left,
  input  logic signed [7:0]  in_hour_right,
  input  logic [6:0]         in_day_mask,
  input  logic [3:0]         in_home_mask,
  input  logic [24:0]        in_icon_flags,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         out_serial_word,
  output logic               out_is_command,
  output logic               out_last_word
);

  localparam logic [slcd_pkg::POS_W-1:0] LAST_POS = slcd_pkg::POS_W'(slcd_pkg::BYTE_COUNT);

  slcd_pkg::frame_t       frame_r;
  logic                   frame_valid_r;
  slcd_pkg::frame_bytes_t fmt_bytes;
  slcd_pkg::frame_bytes_t burst_r;
  logic                   busy_r;
  logic [slcd_pkg::POS_W-1:0] pos_r;
  logic [slcd_pkg::POS_W-1:0] byte_idx;
  logic                   out_beat;
  logic                   load;

  slcd_format u_format (
    .frame (frame_r),
    .bytes (fmt_bytes)
  );

  assign out_valid      = busy_r;
  assign out_is_command = (pos_r == '0);
  assign out_last_word  = (pos_r == LAST_POS);
  assign byte_idx       = pos_r - 1'b1;
  assign out_serial_word = out_is_command ? slcd_pkg::WRITE_CMD : {1'b0, burst_r[byte_idx]};

  assign out_beat = out_valid && out_ready;
  // The buffer frees up either when idle or on the beat that carries the last byte.
  assign load     = frame_valid_r && (!busy_r || (out_beat && out_last_word));
  assign in_ready = !frame_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
      busy_r        <= 1'b0;
      pos_r         <= '0;
    end else begin
      if (in_valid && in_ready) begin
        frame_valid_r <= 1'b1;
      end else if (load) begin
        frame_valid_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
      end else if (out_beat) begin
        if (out_last_word) begin
          busy_r <= 1'b0;
          pos_r  <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r.big_value  <= in_big_value;
      frame_r.hour_left  <= in_hour_left;
      frame_r.hour_right <= in_hour_right;
      frame_r.day_mask   <= in_day_mask;
      frame_r.home_mask  <= in_home_mask;
      frame_r.icon_flags <= in_icon_flags;
    end
    if (load) begin
      burst_r <= fmt_bytes;
    end
  end

  `SLCD_ASSERT(a_pos_range, busy_r |-> (pos_r <= LAST_POS), "burst position out of range")
  `SLCD_ASSERT_NEXT(a_cmd_after_last, out_beat && out_last_word, !out_valid || out_is_command, "burst did not restart with the command word")
  `SLCD_ASSERT(a_full_accept_loads, (in_valid && in_ready && frame_valid_r) |-> load, "pending frame overwritten")
  `SLCD_ASSERT_NEXT(a_idle_pos_zero, !busy_r, pos_r == '0, "idle with nonzero position")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for segment_lcd_frame_formatter: drives display frames, predicts
// the twelve-word write burst of each frame and compares every output beat in order.
// Depends on slcd_pkg and the segment_lcd_frame_formatter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned LONG_HOLD    = 400;
  localparam logic [7:0]  BIG_MINUS    = 8'h20;
  localparam logic [7:0]  HOUR_MINUS   = 8'h02;

  typedef struct packed {
    logic [8:0] serial_word;
    logic       is_command;
    logic       last_word;
  } lcd_word_t;

  typedef struct packed {
    slcd_pkg::frame_t       frame;
    logic                   typed;
    slcd_pkg::frame_bytes_t bytes;
  } frame_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [10:0] in_big_value;
  logic signed [7:0]  in_hour_left;
  logic signed [7:0]  in_hour_right;
  logic [6:0]         in_day_mask;
  logic [3:0]         in_home_mask;
  logic [24:0]        in_icon_flags;
  logic               out_valid;
  logic               out_ready;
  logic [8:0]         out_serial_word;
  logic               out_is_command;
  logic               out_last_word;

  lcd_word_t  pending_words[$];
  frame_row_t directed_rows[$];
  lcd_word_t  seen_word;
  int         fail_count;
  int         cycle_count;
  int         hold_asks;

  segment_lcd_frame_formatter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_big_value    (in_big_value),
    .in_hour_left    (in_hour_left),
    .in_hour_right   (in_hour_right),
    .in_day_mask     (in_day_mask),
    .in_home_mask    (in_home_mask),
    .in_icon_flags   (in_icon_flags),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_serial_word (out_serial_word),
    .out_is_command  (out_is_command),
    .out_last_word   (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] big_glyph(int d);
    case (d)
      0: return 8'h5F;
      1: return 8'h06;
      2: return 8'h6B;
      3: return 8'h2F;
      4: return 8'h36;
      5: return 8'h3D;
      6: return 8'h7D;
      7: return 8'h07;
      8: return 8'h7F;
      default: return 8'h3F;
    endcase
  endfunction

  function automatic logic [7:0] hour_digit(int d);
    case (d)
      0: return 8'hF5;
      1: return 8'h60;
      2: return 8'hB6;
      3: return 8'hF2;
      4: return 8'h63;
      5: return 8'hD3;
      6: return 8'hD7;
      7: return 8'h70;
      8: return 8'hF7;
      default: return 8'hF3;
    endcase
  endfunction

  // Returns {tens, ones} segments of one hour value.
  function automatic logic [15:0] hour_segs(int v);
    logic [7:0] ones;
    logic [7:0] tens;
    ones = '0;
    tens = '0;
    if (v > 99) begin
      ones = '0;
    end else if (v < -9) begin
      ones = HOUR_MINUS;
    end else if (v < 0) begin
      tens = HOUR_MINUS;
      ones = hour_digit((-v) % 10);
    end else begin
      ones = hour_digit(v % 10);
      tens = hour_digit((v / 10) % 10);
    end
    return {tens, ones};
  endfunction

  function automatic slcd_pkg::frame_bytes_t render_glass(slcd_pkg::frame_t fr);
    slcd_pkg::frame_bytes_t b;
    logic [24:0]  f;
    logic [15:0]  hs;
    int           big;
    int           mag;
    int           hund;
    f = fr.icon_flags;
    big = int'(fr.big_value);
    b = '0;
    b[0] = {f[0], fr.day_mask};
    b[1] = {f[1], 7'b0};
    b[2] = {f[2], 7'b0};
    if (big <= 999) begin
      if (big < 0) begin
        // The minus replaces the whole of byte 1, thermometer icon included.
        mag = (big < -99) ? 99 : -big;
        b[1] = BIG_MINUS;
        b[2] = b[2] | big_glyph((mag / 10) % 10);
        b[3] = big_glyph(mag % 10);
      end else begin
        hund = (big / 100) % 10;
        if (hund != 0) b[1] = b[1] | big_glyph(hund);
        b[2] = b[2] | big_glyph((big / 10) % 10);
        b[3] = big_glyph(big % 10);
      end
    end
    b[4] = {fr.home_mask, f[3], f[4], f[5], f[6]};
    b[5] = {4'b0, f[7], 3'b0};
    b[6] = {4'b0, f[8], 3'b0};
    hs = hour_segs(int'(fr.hour_left));
    b[5] = b[5] | hs[7:0];
    b[6] = b[6] | hs[15:8];
    b[7] = {4'b0, f[9], 3'b0};
    b[8] = {4'b0, f[10], 3'b0};
    hs = hour_segs(int'(fr.hour_right));
    b[7] = b[7] | hs[7:0];
    b[8] = b[8] | hs[15:8];
    b[9] = {2'b0, f[11], f[12], f[13], f[14], f[15], f[16]};
    b[10] = {f[17], f[18], f[19], f[20], f[21], f[22], f[23], f[24]};
    return b;
  endfunction

  task automatic queue_burst(input slcd_pkg::frame_bytes_t b);
    lcd_word_t w;
    w.serial_word = slcd_pkg::WRITE_CMD;
    w.is_command  = 1'b1;
    w.last_word   = 1'b0;
    pending_words.push_back(w);
    for (int k = 0; k < slcd_pkg::BYTE_COUNT; k++) begin
      w.serial_word = {1'b0, b[k]};
      w.is_command  = 1'b0;
      w.last_word   = (k == slcd_pkg::BYTE_COUNT - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic add_row(input int big, input int hl, input int hr, input int day,
                         input int home, input logic [24:0] icons, input logic typed,
                         input slcd_pkg::frame_bytes_t bytes);
    frame_row_t row;
    row.frame.big_value  = 11'(big);
    row.frame.hour_left  = 8'(hl);
    row.frame.hour_right = 8'(hr);
    row.frame.day_mask   = 7'(day);
    row.frame.home_mask  = 4'(home);
    row.frame.icon_flags = icons;
    row.typed            = typed;
    row.bytes            = bytes;
    directed_rows.push_back(row);
  endtask

  // Lowers valid only for a real gap, so valid is never dropped and raised in one step.
  task automatic offer_frame(input slcd_pkg::frame_t fr, input int gap, input logic typed,
                             input slcd_pkg::frame_bytes_t typed_bytes);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_big_value  <= fr.big_value;
    in_hour_left  <= fr.hour_left;
    in_hour_right <= fr.hour_right;
    in_day_mask   <= fr.day_mask;
    in_home_mask  <= fr.home_mask;
    in_icon_flags <= fr.icon_flags;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_burst(typed ? typed_bytes : render_glass(fr));
  endtask

  task automatic wait_for_bursts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic slcd_pkg::frame_t random_frame();
    slcd_pkg::frame_t fr;
    int     big_edges[14];
    int     hour_edges[10];
    int     sel;
    big_edges  = '{999, 1000, -99, -100, -9, -10, -1, 0, 99, 100, 9, 10, 1023, -1024};
    hour_edges = '{99, 100, -9, -10, -1, 0, 9, 10, 127, -128};
    sel = $urandom_range(0, 9);
    if (sel < 4) fr.big_value = 11'($urandom_range(0, 2047));
    else if (sel < 7) fr.big_value = 11'(int'($urandom_range(0, 1098)) - 99);
    else if (sel < 9) fr.big_value = 11'(big_edges[$urandom_range(0, 13)]);
    else fr.big_value = 11'(int'($urandom_range(0, 924)) - 1024);
    sel = $urandom_range(0, 9);
    if (sel < 4) fr.hour_left = 8'($urandom_range(0, 255));
    else if (sel < 8) fr.hour_left = 8'(int'($urandom_range(0, 110)) - 10);
    else fr.hour_left = 8'(hour_edges[$urandom_range(0, 9)]);
    sel = $urandom_range(0, 9);
    if (sel < 4) fr.hour_right = 8'($urandom_range(0, 255));
    else if (sel < 8) fr.hour_right = 8'(int'($urandom_range(0, 110)) - 10);
    else fr.hour_right = 8'(hour_edges[$urandom_range(0, 9)]);
    fr.day_mask   = 7'($urandom_range(0, 127));
    fr.home_mask  = 4'($urandom_range(0, 15));
    fr.icon_flags = 25'($urandom);
    return fr;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side ready: mostly short stalls, a few long ones, stretches with none,
  // and one long hold-off on request while the sender keeps offering frames.
  initial begin
    int hold_left;
    int free_left;
    int hold_seen;
    int r;
    hold_left = 0;
    free_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (free_left > 0) begin
        out_ready <= 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          free_left = $urandom_range(20, 80);
          out_ready <= 1'b1;
        end else if (r < 80) begin
          out_ready <= 1'b1;
        end else begin
          hold_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          out_ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected beat: serial_word %h is_command %b last_word %b",
               out_serial_word, out_is_command, out_last_word);
        fail_count++;
      end else begin
        seen_word = pending_words.pop_front();
        if (out_serial_word !== seen_word.serial_word) begin
          $error("serial_word: expected %h, got %h", seen_word.serial_word, out_serial_word);
          fail_count++;
        end
        if (out_is_command !== seen_word.is_command) begin
          $error("is_command: expected %b, got %b", seen_word.is_command, out_is_command);
          fail_count++;
        end
        if (out_last_word !== seen_word.last_word) begin
          $error("last_word: expected %b, got %b", seen_word.last_word, out_last_word);
          fail_count++;
        end
      end
    end
  end

  initial begin
    slcd_pkg::frame_bytes_t no_bytes;
    int           steady_left;
    int           gap;
    no_bytes      = '0;
    steady_left   = 0;
    hold_asks     = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_big_value  <= '0;
    in_hour_left  <= '0;
    in_hour_right <= '0;
    in_day_mask   <= '0;
    in_home_mask  <= '0;
    in_icon_flags <= '0;

    // Rows with bytes typed in: all zero, everything blank, everything lit, both clamps.
    add_row(0, 0, 0, 0, 0, 25'h0, 1'b1, 88'h00_00_F5_F5_F5_F5_00_5F_5F_00_00);
    add_row(1023, 127, 127, 0, 0, 25'h0, 1'b1, 88'h0);
    add_row(1023, 127, 127, 127, 15, 25'h1FFFFFF, 1'b1,
            88'hFF_3F_08_08_08_08_FF_00_80_80_FF);
    add_row(-1024, -128, -128, 0, 0, 25'h0, 1'b1, 88'h00_00_00_02_00_02_00_3F_3F_20_00);
    add_row(999, 99, 99, 'h55, 'hA, 25'h0AAAAAA, 1'b0, no_bytes);
    add_row(1000, 100, 100, 'h2A, 'h5, 25'h1555555, 1'b0, no_bytes);
    add_row(-1, -1, -9, 'h01, 'h1, 25'h0000007, 1'b0, no_bytes);
    add_row(-9, -10, -1, 'h40, 'h8, 25'h0000078, 1'b0, no_bytes);
    add_row(-10, 9, 10, 'h7F, 'hF, 25'h0000780, 1'b0, no_bytes);
    add_row(-99, 10, 9, 'h0F, 'h3, 25'h001F800, 1'b0, no_bytes);
    add_row(-100, -9, -10, 'h70, 'hC, 25'h1FE0000, 1'b0, no_bytes);
    add_row(5, 55, 1, 'h11, 'h2, 25'h0000001, 1'b0, no_bytes);
    add_row(42, 0, 99, 'h22, 'h4, 25'h0000002, 1'b0, no_bytes);
    add_row(100, 42, 7, 'h44, 'h6, 25'h0000004, 1'b0, no_bytes);
    add_row(505, 100, -128, 'h08, 'h9, 25'h1000000, 1'b0, no_bytes);
    add_row(109, 127, 0, 'h33, 'h7, 25'h0020000, 1'b0, no_bytes);
    add_row(-50, 3, 61, 'h7F, 'hF, 25'h1FFFFFF, 1'b0, no_bytes);
    add_row(1, -2, 88, 'h5A, 'hB, 25'h0800400, 1'b0, no_bytes);
    add_row(250, 19, 70, 'h66, 'hD, 25'h0104210, 1'b0, no_bytes);
    add_row(876, -5, 38, 'h19, 'hE, 25'h1ABCDEF, 1'b0, no_bytes);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_frame(directed_rows[i].frame, pick_gap(), directed_rows[i].typed,
                  directed_rows[i].bytes);
    end
    wait_for_bursts();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) begin
        // Hold the output side off and keep offering, so the input side backs up.
        hold_asks++;
        steady_left = 12;
      end
      if (i == 300) wait_for_bursts();
      if (steady_left == 0 && $urandom_range(0, 99) < 4) steady_left = $urandom_range(15, 40);
      if (steady_left > 0) begin
        gap = 0;
        steady_left--;
      end else begin
        gap = pick_gap();
      end
      offer_frame(random_frame(), gap, 1'b0, no_bytes);
    end

    wait_for_bursts();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
